// ===== sv/mrr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_pkg
// shared types, constants and helper functions of the meter read-request
// responder: frame codes, register map, sequencer control words
// ----------------------------------------------------------------------------
package mrr_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdW    = 32;
  localparam int unsigned DiamW  = 9;
  localparam int unsigned DecW   = 3;
  localparam int unsigned RdgW   = 27;
  localparam int unsigned AlarmW = 4;
  localparam int unsigned BcdW   = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned CntW   = 3;

  // largest reading that fits eight decimal digits
  localparam logic [RdgW-1:0] RdgMax = RdgW'(99999999);

  // link bytes
  localparam logic [ByteW-1:0] ShortStart = 8'h10;
  localparam logic [ByteW-1:0] FrameStop  = 8'h16;
  localparam logic [ByteW-1:0] ReqUd2     = 8'h5B;
  localparam logic [ByteW-1:0] LongStart  = 8'h68;
  localparam logic [ByteW-1:0] LongLen    = 8'h0F;
  localparam logic [ByteW-1:0] RspUd      = 8'h08;
  localparam logic [ByteW-1:0] CiVar      = 8'h78;
  localparam logic [ByteW-1:0] DifLow     = 8'h0C;
  localparam logic [ByteW-1:0] VifBase    = 8'h10;
  localparam logic [ByteW-1:0] StOverload = 8'h80;
  localparam logic [ByteW-1:0] StBackflow = 8'h40;
  localparam logic [ByteW-1:0] StLeak     = 8'h20;
  localparam logic [ByteW-1:0] StBattery  = 8'h04;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_ADDR    = 3'd0,
    REG_ID      = 3'd1,
    REG_DIAM    = 3'd2,
    REG_DEC     = 3'd3,
    REG_READING = 3'd4,
    REG_ALARM   = 3'd5
  } cfg_idx_e;

  // sequencer opcodes
  typedef enum logic [1:0] {
    OP_IDLE = 2'd0,
    OP_WAIT = 2'd1,
    OP_EMIT = 2'd2
  } op_e;

  // reply byte sources
  typedef enum logic [3:0] {
    SRC_CONST = 4'd0,
    SRC_ADDR  = 4'd1,
    SRC_ID0   = 4'd2,
    SRC_ID1   = 4'd3,
    SRC_ID2   = 4'd4,
    SRC_ID3   = 4'd5,
    SRC_STAT  = 4'd6,
    SRC_DIF   = 4'd7,
    SRC_VIF   = 4'd8,
    SRC_RD0   = 4'd9,
    SRC_RD1   = 4'd10,
    SRC_RD2   = 4'd11,
    SRC_RD3   = 4'd12,
    SRC_SUM   = 4'd13
  } src_e;

  typedef struct packed {
    op_e              op;
    src_e             src;
    logic [ByteW-1:0] konst;
    logic             add;   // byte goes into the checksum
    logic             last;  // closing byte, jump back to idle
  } ctl_t;

  localparam int unsigned ProgLen = 23;
  localparam int unsigned PcW     = $clog2(ProgLen);

  function automatic ctl_t mrr_rom(input logic [PcW-1:0] pc);
    ctl_t w;
    w = '{OP_IDLE, SRC_CONST, 8'h00, 1'b0, 1'b0};
    case (pc)
      5'd0:  w = '{OP_IDLE, SRC_CONST, 8'h00,     1'b0, 1'b0};
      5'd1:  w = '{OP_WAIT, SRC_CONST, 8'h00,     1'b0, 1'b0};
      5'd2:  w = '{OP_EMIT, SRC_CONST, LongStart, 1'b0, 1'b0};
      5'd3:  w = '{OP_EMIT, SRC_CONST, LongLen,   1'b0, 1'b0};
      5'd4:  w = '{OP_EMIT, SRC_CONST, LongLen,   1'b0, 1'b0};
      5'd5:  w = '{OP_EMIT, SRC_CONST, LongStart, 1'b0, 1'b0};
      5'd6:  w = '{OP_EMIT, SRC_CONST, RspUd,     1'b1, 1'b0};
      5'd7:  w = '{OP_EMIT, SRC_ADDR,  8'h00,     1'b1, 1'b0};
      5'd8:  w = '{OP_EMIT, SRC_CONST, CiVar,     1'b1, 1'b0};
      5'd9:  w = '{OP_EMIT, SRC_CONST, LongLen,   1'b1, 1'b0};
      5'd10: w = '{OP_EMIT, SRC_ID0,   8'h00,     1'b1, 1'b0};
      5'd11: w = '{OP_EMIT, SRC_ID1,   8'h00,     1'b1, 1'b0};
      5'd12: w = '{OP_EMIT, SRC_ID2,   8'h00,     1'b1, 1'b0};
      5'd13: w = '{OP_EMIT, SRC_ID3,   8'h00,     1'b1, 1'b0};
      5'd14: w = '{OP_EMIT, SRC_STAT,  8'h00,     1'b1, 1'b0};
      5'd15: w = '{OP_EMIT, SRC_DIF,   8'h00,     1'b1, 1'b0};
      5'd16: w = '{OP_EMIT, SRC_VIF,   8'h00,     1'b1, 1'b0};
      5'd17: w = '{OP_EMIT, SRC_RD0,   8'h00,     1'b1, 1'b0};
      5'd18: w = '{OP_EMIT, SRC_RD1,   8'h00,     1'b1, 1'b0};
      5'd19: w = '{OP_EMIT, SRC_RD2,   8'h00,     1'b1, 1'b0};
      5'd20: w = '{OP_EMIT, SRC_RD3,   8'h00,     1'b1, 1'b0};
      5'd21: w = '{OP_EMIT, SRC_SUM,   8'h00,     1'b0, 1'b0};
      5'd22: w = '{OP_EMIT, SRC_CONST, FrameStop, 1'b0, 1'b1};
      default: w = '{OP_IDLE, SRC_CONST, 8'h00, 1'b0, 1'b0};
    endcase
    return w;
  endfunction

  // pipe diameter in mm to code, unknown sizes give code 1
  function automatic logic [3:0] diam_code(input logic [DiamW-1:0] mm);
    logic [3:0] c;
    c = 4'd1;
    case (mm)
      9'd15:   c = 4'd1;
      9'd20:   c = 4'd2;
      9'd25:   c = 4'd3;
      9'd32:   c = 4'd4;
      9'd40:   c = 4'd5;
      9'd50:   c = 4'd6;
      9'd80:   c = 4'd7;
      9'd100:  c = 4'd8;
      9'd150:  c = 4'd9;
      9'd200:  c = 4'd10;
      9'd250:  c = 4'd11;
      9'd300:  c = 4'd12;
      default: c = 4'd1;
    endcase
    return c;
  endfunction

  function automatic logic [ByteW-1:0] status_byte(input logic [AlarmW-1:0] al);
    logic [ByteW-1:0] s;
    s = '0;
    if (al[3]) s = s | StOverload;
    if (al[2]) s = s | StBackflow;
    if (al[1]) s = s | StLeak;
    if (al[0]) s = s | StBattery;
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mrr_rx_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_rx_if
// received-byte channel: valid/ready handshake carrying one link byte
// ----------------------------------------------------------------------------
interface mrr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/mrr_tx_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_tx_if
// reply channel: valid/ready handshake carrying one reply byte and a last flag
// ----------------------------------------------------------------------------
interface mrr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== sv/mrr_bcd.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mrr_bcd
// binary to eight-digit bcd converter, shift-and-add-3, one bit per cycle
// ----------------------------------------------------------------------------
module mrr_bcd (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mrr_pkg::RdgW-1:0]  bin_i,
  output logic                      done_o,
  output logic [mrr_pkg::BcdW-1:0]  bcd_o
);
  import mrr_pkg::*;

  localparam int unsigned BitCntW = $clog2(RdgW + 1);
  localparam int unsigned Digits  = BcdW / 4;

  logic [RdgW-1:0]    bin_q;
  logic [BcdW-1:0]    bcd_q;
  logic [BcdW-1:0]    adj;
  logic [BitCntW-1:0] cnt_q;
  logic               done_q;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < Digits; d++) begin
      if (bcd_q[4*d +: 4] > 4'd4) begin
        adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
      end else begin
        adj[4*d +: 4] = bcd_q[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= BitCntW'(RdgW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == BitCntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= (bin_i > RdgMax) ? RdgMax : bin_i;
      bcd_q <= '0;
    end else if (cnt_q != '0) begin
      bin_q <= {bin_q[RdgW-2:0], 1'b0};
      bcd_q <= {adj[BcdW-2:0], bin_q[RdgW-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule
`default_nettype wire

// ===== sv/meter_read_request_responder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// meter_read_request_responder
// slave side of a wired water-meter link: answers a REQ_UD2 short frame with
// a 21-byte REP_UD long frame
// ----------------------------------------------------------------------------
// Each received byte is taken while the sequencer is idle. When the fifth
// byte completes a valid REQ_UD2 frame for this address, the block stops
// taking bytes and a microcoded sequencer runs the reply. The reading
// conversion starts at the edge that takes the closing byte and runs in the
// bit-serial bcd converter, the sequencer stays in its wait step until the
// converter is done, then 21 reply words are loaded, one per cycle when the
// sink is ready, and each word leaves through the output register. Input is
// taken again as soon as the last word is loaded. Rejected frames and
// ignored bytes give no reply. Registers sit on an APB port at byte address
// 4*index and should only be written while no reply is pending.
// ----------------------------------------------------------------------------
module meter_read_request_responder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mrr_rx_if.sink                       rx_i,
  mrr_tx_if.source                     tx_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mrr_pkg::AddrW-1:0]    paddr,
  input  logic [mrr_pkg::DataW-1:0]    pwdata,
  output logic [mrr_pkg::DataW-1:0]    prdata,
  output logic                         pready
);
  import mrr_pkg::*;

  // configuration
  logic [ByteW-1:0]  slave_addr_q;
  logic [IdW-1:0]    meter_id_q;
  logic [DiamW-1:0]  diam_q;
  logic [DecW-1:0]   dec_q;
  logic [RdgW-1:0]   reading_q;
  logic [AlarmW-1:0] alarm_q;

  cfg_idx_e reg_idx;
  logic     cfg_wr;

  assign reg_idx = cfg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= ByteW'(1);
      meter_id_q   <= IdW'(152187990);
      diam_q       <= DiamW'(15);
      dec_q        <= DecW'(3);
      reading_q    <= RdgW'(12345678);
      alarm_q      <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ADDR:    slave_addr_q <= pwdata[ByteW-1:0];
        REG_ID:      meter_id_q   <= pwdata[IdW-1:0];
        REG_DIAM:    diam_q       <= pwdata[DiamW-1:0];
        REG_DEC:     dec_q        <= pwdata[DecW-1:0];
        REG_READING: reading_q    <= pwdata[RdgW-1:0];
        REG_ALARM:   alarm_q      <= pwdata[AlarmW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ADDR:    prdata = DataW'(slave_addr_q);
      REG_ID:      prdata = DataW'(meter_id_q);
      REG_DIAM:    prdata = DataW'(diam_q);
      REG_DEC:     prdata = DataW'(dec_q);
      REG_READING: prdata = DataW'(reading_q);
      REG_ALARM:   prdata = DataW'(alarm_q);
      default:     prdata = '0;
    endcase
  end

  // sequencer and receive path
  logic [PcW-1:0]   pc_q;
  ctl_t             ctl;
  logic [CntW-1:0]  rx_cnt_q;
  logic [ByteW-1:0] frame_q [4];
  logic             rx_fire;
  logic             frame_ok;
  logic             start;
  logic             emit_go;
  logic [ByteW-1:0] sum_q;
  logic [ByteW-1:0] word;
  logic             tx_vld_q;
  logic [ByteW-1:0] tx_byte_q;
  logic             tx_last_q;
  logic             bcd_done;
  logic [BcdW-1:0]  rd_bcd;

  assign ctl        = mrr_rom(pc_q);
  assign rx_i.ready = (ctl.op == OP_IDLE);
  assign rx_fire    = rx_i.valid && rx_i.ready;

  assign frame_ok = (rx_cnt_q == CntW'(4)) && (frame_q[0] == ShortStart) &&
                    (rx_i.rx_byte == FrameStop) &&
                    (frame_q[3] == ByteW'(frame_q[1] + frame_q[2])) &&
                    (frame_q[1] == ReqUd2) && (frame_q[2] == slave_addr_q);
  assign start    = rx_fire && frame_ok;
  assign emit_go  = (ctl.op == OP_EMIT) && (!tx_vld_q || tx_o.ready);

  mrr_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .bin_i   (reading_q),
    .done_o  (bcd_done),
    .bcd_o   (rd_bcd)
  );

  always_comb begin
    case (ctl.src)
      SRC_CONST: word = ctl.konst;
      SRC_ADDR:  word = slave_addr_q;
      SRC_ID0:   word = meter_id_q[7:0];
      SRC_ID1:   word = meter_id_q[15:8];
      SRC_ID2:   word = meter_id_q[23:16];
      SRC_ID3:   word = meter_id_q[31:24];
      SRC_STAT:  word = status_byte(alarm_q);
      SRC_DIF:   word = {diam_code(diam_q), DifLow[3:0]};
      SRC_VIF:   word = VifBase | ByteW'(dec_q);
      SRC_RD0:   word = rd_bcd[7:0];
      SRC_RD1:   word = rd_bcd[15:8];
      SRC_RD2:   word = rd_bcd[23:16];
      SRC_RD3:   word = rd_bcd[31:24];
      SRC_SUM:   word = sum_q;
      default:   word = ctl.konst;
    endcase
  end

  // frame bytes, stored only once a start byte has been seen
  always_ff @(posedge clk_i) begin
    if (rx_fire && (rx_cnt_q < CntW'(4)) &&
        !((rx_cnt_q == '0) && (rx_i.rx_byte != ShortStart))) begin
      frame_q[rx_cnt_q[1:0]] <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cnt_q <= '0;
      pc_q     <= '0;
      sum_q    <= '0;
      tx_vld_q <= 1'b0;
    end else begin
      if (rx_fire) begin
        if (rx_cnt_q == CntW'(4)) begin
          rx_cnt_q <= '0;
        end else if (!((rx_cnt_q == '0) && (rx_i.rx_byte != ShortStart))) begin
          rx_cnt_q <= rx_cnt_q + 1'b1;
        end
      end

      if (emit_go) begin
        tx_vld_q <= 1'b1;
      end else if (tx_o.ready) begin
        tx_vld_q <= 1'b0;
      end

      case (ctl.op)
        OP_IDLE: begin
          sum_q <= '0;
          if (start) begin
            pc_q <= pc_q + 1'b1;
          end
        end
        OP_WAIT: begin
          if (bcd_done) begin
            pc_q <= pc_q + 1'b1;
          end
        end
        OP_EMIT: begin
          if (emit_go) begin
            if (ctl.add) begin
              sum_q <= sum_q + word;
            end
            pc_q <= ctl.last ? '0 : pc_q + 1'b1;
          end
        end
        default: pc_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      tx_byte_q <= word;
      tx_last_q <= ctl.last;
    end
  end

  assign tx_o.valid     = tx_vld_q;
  assign tx_o.tx_byte   = tx_byte_q;
  assign tx_o.last_byte = tx_last_q;

endmodule
`default_nettype wire

// ===== tb/sv/meter_read_request_responder_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// meter_read_request_responder_test
// self-checking bench for the meter read-request responder
// ----------------------------------------------------------------------------
// Received bytes go in on the rx channel and reply words come back on the tx
// channel. Both sides pause at random. A behavioral copy of the responder,
// with its own copy of the registers, predicts each reply long frame. Every
// reply word is checked against the oldest pending one. A directed table
// covers reset values, noise and rejected frames. Random traffic then runs
// under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module meter_read_request_responder_test;
  import mrr_pkg::*;

  localparam int DrainCycles = 64;
  localparam int StallLimit  = 1000;  // cycles with nothing moving
  localparam int PhaseWords  = 60;    // counted rx words per random phase
  localparam int ReplyLen    = 21;

  typedef enum logic [1:0] {
    WANT_MODEL,
    WANT_NONE,
    WANT_RESET_REPLY
  } want_e;

  typedef struct packed {
    logic [7:0] rx;
    want_e      want;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_word_t;

  typedef struct packed {
    logic [7:0]  addr;
    logic [31:0] id;
    logic [8:0]  diam;
    logic [2:0]  dec;
    logic [26:0] rdg;
    logic [3:0]  alarm;
  } cfg_set_t;

  // directed rows, all under reset register values (address 1)
  localparam stim_row_t DirectedRows [27] = '{
    '{8'h00, WANT_NONE},          // noise while hunting for start
    '{8'hFF, WANT_NONE},
    '{ShortStart, WANT_NONE},     // good request
    '{ReqUd2, WANT_NONE},
    '{8'h01, WANT_NONE},
    '{8'h5C, WANT_NONE},
    '{FrameStop, WANT_RESET_REPLY},
    '{ShortStart, WANT_NONE},     // bad checksum
    '{ReqUd2, WANT_NONE},
    '{8'h01, WANT_NONE},
    '{8'h5D, WANT_NONE},
    '{FrameStop, WANT_NONE},
    '{ShortStart, WANT_NONE},     // other address
    '{ReqUd2, WANT_NONE},
    '{8'h02, WANT_NONE},
    '{8'h5D, WANT_NONE},
    '{FrameStop, WANT_NONE},
    '{ShortStart, WANT_NONE},     // bad stop byte
    '{ReqUd2, WANT_NONE},
    '{8'h01, WANT_NONE},
    '{8'h5C, WANT_NONE},
    '{8'h17, WANT_NONE},
    '{ShortStart, WANT_NONE},     // wrong control field
    '{8'h5A, WANT_NONE},
    '{8'h01, WANT_NONE},
    '{8'h5B, WANT_NONE},
    '{FrameStop, WANT_NONE}
  };

  // reply to address 1 with all registers at reset
  localparam logic [7:0] ResetReply [ReplyLen] = '{
    8'h68, 8'h0F, 8'h0F, 8'h68, 8'h08, 8'h01, 8'h78, 8'h0F,
    8'h56, 8'h34, 8'h12, 8'h09, 8'h00, 8'h1C, 8'h13,
    8'h78, 8'h56, 8'h34, 8'h12, 8'h78, 8'h16
  };

  localparam logic [8:0] PipeSizes [12] = '{
    9'd15, 9'd20, 9'd25, 9'd32, 9'd40, 9'd50,
    9'd80, 9'd100, 9'd150, 9'd200, 9'd250, 9'd300
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic        pready;

  mrr_rx_if rx ();
  mrr_tx_if tx ();

  meter_read_request_responder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx),
    .tx_o    (tx),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register copy of the responder
  logic [7:0]  link_addr;
  logic [31:0] meter_no;
  logic [8:0]  pipe_mm;
  logic [2:0]  dec_places;
  logic [26:0] reading_units;
  logic [3:0]  alarm_bits;

  // short frame being gathered
  logic [7:0]  frame_buf [4];
  int          frame_fill;
  int          words_taken;

  logic [7:0]  model_reply [ReplyLen];
  reply_word_t pending_reply [$];
  int          fail_cnt;
  bit          no_idle;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // updates the frame state for one received byte, returns 1 when the byte
  // completes an accepted request and fills model_reply with the answer
  function automatic bit predict_reply(input logic [7:0] b);
    logic [7:0]  st;
    logic [7:0]  sum;
    logic [31:0] rd;
    logic [3:0]  code;
    int unsigned n;
    if (frame_fill == 0 && b != ShortStart) return 1'b0;
    words_taken++;
    if (frame_fill < 4) begin
      frame_buf[frame_fill] = b;
      frame_fill++;
      return 1'b0;
    end
    frame_fill = 0;
    if (frame_buf[0] != ShortStart || b != FrameStop ||
        frame_buf[3] != 8'(frame_buf[1] + frame_buf[2]) ||
        frame_buf[1] != ReqUd2 || frame_buf[2] != link_addr) return 1'b0;

    st = '0;
    if (alarm_bits[3]) st |= StOverload;
    if (alarm_bits[2]) st |= StBackflow;
    if (alarm_bits[1]) st |= StLeak;
    if (alarm_bits[0]) st |= StBattery;

    code = 4'd1;
    for (int i = 0; i < 12; i++) begin
      if (PipeSizes[i] == pipe_mm) code = 4'(i + 1);
    end

    // reading saturates at eight decimal digits
    n = reading_units;
    if (n > 99999999) n = 99999999;
    rd = '0;
    for (int i = 0; i < 8; i++) begin
      rd[4*i +: 4] = 4'(n % 10);
      n = n / 10;
    end

    model_reply[0]  = LongStart;
    model_reply[1]  = LongLen;
    model_reply[2]  = LongLen;
    model_reply[3]  = LongStart;
    model_reply[4]  = RspUd;
    model_reply[5]  = frame_buf[2];
    model_reply[6]  = CiVar;
    model_reply[7]  = LongLen;
    for (int i = 0; i < 4; i++) begin
      model_reply[8 + i]  = meter_no[8*i +: 8];
      model_reply[15 + i] = rd[8*i +: 8];
    end
    model_reply[12] = st;
    model_reply[13] = {code, DifLow[3:0]};
    model_reply[14] = VifBase | {5'b0, dec_places};
    sum = '0;
    for (int i = 4; i < 19; i++) sum = sum + model_reply[i];
    model_reply[19] = sum;
    model_reply[20] = FrameStop;
    return 1'b1;
  endfunction

  task automatic send_word(input logic [7:0] b, input want_e want);
    bit hit;
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk_i);
    while (rx.ready !== 1'b1) @(posedge clk_i);
    hit = predict_reply(b);
    for (int i = 0; i < ReplyLen; i++) begin
      if (want == WANT_MODEL && hit)
        pending_reply.push_back('{data: model_reply[i], last: (i == ReplyLen - 1)});
      else if (want == WANT_RESET_REPLY)
        pending_reply.push_back('{data: ResetReply[i], last: (i == ReplyLen - 1)});
    end
  endtask

  // one word followed by an occasional gap or a wait for the reply to drain
  task automatic feed(input logic [7:0] b, input want_e want);
    send_word(b, want);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end else if (!no_idle && $urandom_range(0, 59) == 0 && pending_reply.size() != 0) begin
      rx.valid <= 1'b0;
      while (pending_reply.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    rx.valid <= 1'b0;
    while (pending_reply.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_setting(input cfg_set_t s);
    cfg_idx_e   idx;
    logic [31:0] v;
    for (int i = 0; i <= int'(REG_ALARM); i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        REG_ADDR:    v = 32'(s.addr);
        REG_ID:      v = s.id;
        REG_DIAM:    v = 32'(s.diam);
        REG_DEC:     v = 32'(s.dec);
        REG_READING: v = 32'(s.rdg);
        default:     v = 32'(s.alarm);
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= AddrW'({idx, 2'b00});
      pwdata  <= v;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (pready !== 1'b1) @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    link_addr     = s.addr;
    meter_no      = s.id;
    pipe_mm       = s.diam;
    dec_places    = s.dec;
    reading_units = s.rdg;
    alarm_bits    = s.alarm;
  endtask

  function automatic cfg_set_t random_setting();
    cfg_set_t s;
    s.addr = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      for (int i = 0; i < 8; i++) s.id[4*i +: 4] = 4'($urandom_range(0, 9));
    end else begin
      s.id = $urandom;
    end
    if ($urandom_range(0, 3) != 0) s.diam = PipeSizes[$urandom_range(0, 11)];
    else s.diam = 9'($urandom_range(0, 511));
    s.dec = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 4) != 0) s.rdg = 27'($urandom_range(0, 99999999));
    else s.rdg = 27'($urandom_range(100000000, 134217727));
    s.alarm = 4'($urandom_range(0, 15));
    return s;
  endfunction

  // mostly well-formed requests, the rest broken frames and line noise
  task automatic random_traffic(input int target);
    int          stop_at;
    int          kind;
    int          n;
    logic [7:0]  fr [5];
    stop_at = words_taken + target;
    while (words_taken < stop_at) begin
      kind = $urandom_range(0, 9);
      fr[0] = ShortStart;
      fr[1] = ReqUd2;
      fr[2] = (kind == 6) ? 8'($urandom_range(0, 255)) : link_addr;
      fr[3] = 8'(fr[1] + fr[2]);
      fr[4] = FrameStop;
      if (kind == 7) fr[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
      if (kind <= 7) begin
        for (int i = 0; i < 5; i++) feed(fr[i], WANT_MODEL);
      end else begin
        n = (kind == 8) ? $urandom_range(1, 3) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) feed(8'($urandom_range(0, 255)), WANT_MODEL);
      end
    end
  endtask

  // reply side: checks each word, ready drops in random bursts
  initial begin : reply_sink
    int          stall;
    reply_word_t exp_word;
    stall = 0;
    tx.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (tx.valid === 1'b1 && tx.ready === 1'b1) begin
        if (pending_reply.size() == 0) begin
          $error("tx_byte: unexpected word %02h, no reply pending", tx.tx_byte);
          fail_cnt++;
        end else begin
          exp_word = pending_reply.pop_front();
          if (tx.tx_byte !== exp_word.data) begin
            $error("tx_byte: expected %02h, got %02h", exp_word.data, tx.tx_byte);
            fail_cnt++;
          end
          if (tx.last_byte !== exp_word.last) begin
            $error("last_byte: expected %0b, got %0b", exp_word.last, tx.last_byte);
            fail_cnt++;
          end
        end
      end
      if (stall > 0) stall--;
      else if (!no_idle && $urandom_range(0, 9) == 0) stall = $urandom_range(1, 15);
      tx.ready <= (stall == 0);
    end
  end

  initial begin : watchdog
    int silent;
    silent = 0;
    while (silent < StallLimit) begin
      @(posedge clk_i);
      if ((rx.valid === 1'b1 && rx.ready === 1'b1) ||
          (tx.valid === 1'b1 && tx.ready === 1'b1)) silent = 0;
      else silent++;
    end
    $display("meter_read_request_responder_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    cfg_set_t s;
    fail_cnt    = 0;
    no_idle     = 1'b0;
    frame_fill  = 0;
    words_taken = 0;
    link_addr     = 8'd1;
    meter_no      = 32'h0912_3456;
    pipe_mm       = 9'd15;
    dec_places    = 3'd3;
    reading_units = 27'd12345678;
    alarm_bits    = 4'd0;
    rst_ni     <= 1'b0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) feed(DirectedRows[i].rx, DirectedRows[i].want);
    settle();

    // all-zero registers, unknown diameter
    load_setting('{8'h00, 32'h0, 9'd0, 3'd0, 27'd0, 4'h0});
    random_traffic(PhaseWords);
    settle();

    // all ones: non-bcd meter number, saturated reading, wide decimals
    load_setting('{8'hFF, 32'hFFFF_FFFF, 9'h1FF, 3'd7, 27'h7FF_FFFF, 4'hF});
    random_traffic(PhaseWords);
    settle();

    // largest legal values
    load_setting('{8'hFE, 32'h9999_9999, 9'd300, 3'd4, 27'd99999999, 4'hA});
    random_traffic(PhaseWords);
    settle();

    for (int p = 0; p < 4; p++) begin
      s = random_setting();
      load_setting(s);
      if (p == 3) no_idle = 1'b1;
      random_traffic(PhaseWords);
      settle();
    end

    if (fail_cnt == 0) begin
      $display("meter_read_request_responder_test: PASS");
    end else begin
      $display("meter_read_request_responder_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
